// File: design/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and helpers for the vertex skinning block
// Transaction structs, lane control struct and saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbs_pkg;

  localparam int MAX_BONES_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROWS = 3;
  localparam int COLS = 4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  typedef struct packed {
    logic               op;
    logic [4:0]         bone;
    logic [3:0]         element;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic               last_weight;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
  } out_t;

  // One issue slot for every lane.
  typedef struct packed {
    logic       issue;
    logic       xf;     // 0 accumulate, 1 transform
    logic       nrm;    // transform the normal (no translation)
    logic [1:0] col;
    logic       first;
    logic       last;
  } lane_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: design/lbs_ram.sv
// ----------------------------------------------------------------------------
// lbs_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/lbs_lane.sv
// ----------------------------------------------------------------------------
// lbs_lane: one matrix row of the skinning datapath
// Holds the row's bone words and blend words, one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbs_lane import lbs_pkg::*; #(
  parameter int MAX_BONES = MAX_BONES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int AW = $clog2(MAX_BONES * COLS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [31:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  input  lane_ctrl_t         ctrl,
  input  logic               clr,
  input  logic signed [31:0] weight,
  input  logic signed [31:0] pos [ROWS],
  input  logic signed [31:0] nrm [ROWS],
  output logic signed [31:0] res_pos,
  output logic signed [31:0] res_nrm
);

  logic [31:0]        rd_data;
  lane_ctrl_t         c1, c2;
  logic signed [31:0] acc [COLS];
  logic signed [63:0] prod;
  logic signed [65:0] sum;
  logic signed [31:0] op_a, op_b, vec;
  logic signed [63:0] shifted;
  logic signed [65:0] term, s;

  lbs_ram #(.WIDTH(32), .DEPTH(MAX_BONES * COLS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    case (c1.col)
      2'd0:    vec = c1.nrm ? nrm[0] : pos[0];
      2'd1:    vec = c1.nrm ? nrm[1] : pos[1];
      default: vec = c1.nrm ? nrm[2] : pos[2];
    endcase
    op_a = c1.xf ? acc[c1.col] : $signed(rd_data);
    op_b = c1.xf ? vec : weight;
  end

  // Arithmetic shift of the exact product gives the floor.
  assign shifted = prod >>> FRAC_BITS;
  assign term    = 66'(shifted);

  always_comb begin
    if (c2.first) begin
      s = (c2.nrm ? 66'sd0 : 66'(acc[COLS-1])) + term;
    end else begin
      s = sum + term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      for (int i = 0; i < COLS; i++) acc[i] <= '0;
    end else begin
      c1 <= ctrl;
      c2 <= c1;
      if (clr) begin
        for (int i = 0; i < COLS; i++) acc[i] <= '0;
      end else if (c2.issue && !c2.xf) begin
        acc[c2.col] <= sat32(66'(acc[c2.col]) + term);
      end
    end
    prod <= op_a * op_b;
    if (c2.issue && c2.xf) begin
      sum <= s;
      if (c2.last) begin
        if (c2.nrm) res_nrm <= sat32(s);
        else        res_pos <= sat32(s);
      end
    end
  end

endmodule

// File: design/linear_blend_vertex_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning: matrix-palette skinning, Q16.16 fixed point
// Three row lanes hold bone rows and blend rows; a merge register collects
// the skinned position and normal.
// Load transaction: done on acceptance. Weight: when accumulated, 4 column
// issues go through each lane's multiplier, then drain. Last weight adds the
// transform (6 issues, then drain) and a merge. Pass-through last weight goes
// straight to merge. One transaction in flight at a time.
// Reset (rst, synchronous): clears control, blend rows and enables skinning;
// bone store contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_blend_vertex_skinning import lbs_pkg::*; #(
  parameter int MAX_BONES = MAX_BONES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  localparam int AW = $clog2(MAX_BONES * COLS);

  typedef enum logic [1:0] {IDLE, ACC, XF, MERGE} state_t;

  state_t             state;
  logic [2:0]         cnt;
  logic               en;
  logic               held_en, held_last;
  logic [4:0]         held_bone;
  logic signed [31:0] weight;
  logic signed [31:0] pos [ROWS];
  logic signed [31:0] nrm [ROWS];
  lane_ctrl_t         ctrl;
  logic               clr;
  logic               accept, bone_ok;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic signed [31:0] res_pos [ROWS];
  logic signed [31:0] res_nrm [ROWS];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != IDLE);
  assign accept    = in_valid && !in_stall;
  assign bone_ok   = {4'b0000, in_data.bone} < 9'(MAX_BONES);
  assign wr_addr   = AW'({in_data.bone, in_data.element[1:0]});
  assign rd_addr   = AW'({held_bone, ctrl.col});

  // Drive the issue slot from the sequencer count.
  always_comb begin
    ctrl = '0;
    clr  = 1'b0;
    unique case (state)
      ACC: begin
        ctrl.issue = (cnt < 3'd4);
        ctrl.col   = cnt[1:0];
      end
      XF: begin
        ctrl.issue = (cnt < 3'd6);
        ctrl.xf    = 1'b1;
        ctrl.nrm   = (cnt >= 3'd3);
        ctrl.col   = (cnt >= 3'd3) ? 2'(cnt - 3'd3) : cnt[1:0];
        ctrl.first = (cnt == 3'd0) || (cnt == 3'd3);
        ctrl.last  = (cnt == 3'd2) || (cnt == 3'd5);
      end
      MERGE:   clr = !out_valid || !out_stall;
      default: ;
    endcase
  end

  for (genvar l = 0; l < ROWS; l++) begin : g_lane
    logic lane_wr;
    assign lane_wr = accept && (in_data.op == OP_LOAD) && bone_ok &&
                     (in_data.element[3:2] == 2'(l));
    lbs_lane #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (lane_wr),
      .wr_addr (wr_addr),
      .wr_data (in_data.value),
      .rd_addr (rd_addr),
      .ctrl    (ctrl),
      .clr     (clr),
      .weight  (weight),
      .pos     (pos),
      .nrm     (nrm),
      .res_pos (res_pos[l]),
      .res_nrm (res_nrm[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      en        <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) en <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          cnt <= '0;
          if (accept && in_data.op == OP_WEIGHT) begin
            if (en && !in_data.value[31] && (in_data.value != '0) && bone_ok) begin
              state <= ACC;
            end else if (in_data.last_weight) begin
              state <= en ? XF : MERGE;
            end
          end
        end
        ACC: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd5) begin
            cnt   <= '0;
            state <= held_last ? XF : IDLE;
          end
        end
        XF: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) state <= MERGE;
        end
        MERGE: begin
          // Hold until the output register is free, then merge the lanes.
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
    if (accept) begin
      held_bone <= in_data.bone;
      held_last <= in_data.last_weight;
      held_en   <= en;
      weight    <= in_data.value;
      pos[0]    <= in_data.pos_x;
      pos[1]    <= in_data.pos_y;
      pos[2]    <= in_data.pos_z;
      nrm[0]    <= in_data.nrm_x;
      nrm[1]    <= in_data.nrm_y;
      nrm[2]    <= in_data.nrm_z;
    end
    if (state == MERGE && (!out_valid || !out_stall)) begin
      out_data.out_pos_x <= held_en ? res_pos[0] : pos[0];
      out_data.out_pos_y <= held_en ? res_pos[1] : pos[1];
      out_data.out_pos_z <= held_en ? res_pos[2] : pos[2];
      out_data.out_nrm_x <= held_en ? res_nrm[0] : nrm[0];
      out_data.out_nrm_y <= held_en ? res_nrm[1] : nrm[1];
      out_data.out_nrm_z <= held_en ? res_nrm[2] : nrm[2];
    end
  end

endmodule
